### hdl/tosr_pkg.sv
package tosr_pkg;

    localparam int DEF_STACK_DEPTH   = 64;
    localparam int DEF_NUM_REGISTERS = 16;

    localparam int CMD_W    = 3;
    localparam int TAG_W    = 3;
    localparam int BITS_W   = 64;
    localparam int RIDX_W   = 5;
    localparam int STATUS_W = 3;
    localparam int DEPTH_W  = 7;

    localparam int S_TDATA_W = 72;
    localparam int S_TUSER_W = 3;
    localparam int M_TDATA_W = 80;
    localparam int M_TUSER_W = 3;

    typedef enum logic [CMD_W-1:0] {
        CMD_PUSH  = 3'd0,
        CMD_POP   = 3'd1,
        CMD_CLEAR = 3'd2,
        CMD_DUP   = 3'd3,
        CMD_SWAP  = 3'd4,
        CMD_LOAD  = 3'd5,
        CMD_STORE = 3'd6
    } cmd_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK       = 3'd0,
        ST_EMPTY    = 3'd1,
        ST_FEW      = 3'd2,
        ST_RANGE    = 3'd3,
        ST_REGEMPTY = 3'd4,
        ST_FULL     = 3'd5
    } status_t;

    typedef struct packed {
        logic [TAG_W-1:0]  tag;
        logic [BITS_W-1:0] bits;
    } entry_t;

    typedef struct packed {
        logic take_up;
        logic take_down;
    } cell_ctrl_t;

endpackage

### hdl/tosr_cell.sv
module tosr_cell
    import tosr_pkg::*;
(
    input  logic       clk,
    input  cell_ctrl_t ctrl,
    input  entry_t     up_in,
    input  entry_t     down_in,
    output entry_t     q,
    output entry_t     d
);

    entry_t entry_reg;
    entry_t entry_next;

    always_comb
    begin
        priority if (ctrl.take_up)
        begin
            entry_next = up_in;
        end
        else if (ctrl.take_down)
        begin
            entry_next = down_in;
        end
        else
        begin
            entry_next = entry_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign q = entry_reg;
    assign d = entry_next;

endmodule

### hdl/tosr_regfile.sv
module tosr_regfile
    import tosr_pkg::*;
#(
    parameter int NUM_REGISTERS = DEF_NUM_REGISTERS,
    parameter int RW = (NUM_REGISTERS > 1) ? $clog2(NUM_REGISTERS) : 1
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          wr_en,
    input  logic [RW-1:0] wr_idx,
    input  entry_t        wr_entry,
    input  logic [RW-1:0] rd_idx,
    output entry_t        rd_entry,
    output logic          rd_valid
);

    entry_t                   file_reg [NUM_REGISTERS];
    logic [NUM_REGISTERS-1:0] valid_reg;
    logic [NUM_REGISTERS-1:0] valid_next;

    always_comb
    begin
        valid_next = valid_reg;
        if (wr_en)
        begin
            valid_next[wr_idx] = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            file_reg[wr_idx] <= wr_entry;
        end
    end

    assign rd_entry = file_reg[rd_idx];
    assign rd_valid = valid_reg[rd_idx];

endmodule

### hdl/typed_operand_stack_with_registers.sv
// Channel   Dir  Payload (low bit first)
// s_*       in   tdata: command, value_bits, register_index; tuser: value_type
// m_*       out  tdata: status, top_valid, top_bits, depth; tuser: top_type
//
// One beat is accepted per cycle; its result beat is valid in the next cycle.
// Every command finishes in the cycle in which the row of stack cells
// shifts by one place, swaps its first two cells or holds.
// Reset clears the depth count, the register valid marks and the output valid.
// The stack cells and register payloads are not reset.
// An input beat is taken while the output register is empty or being drained.
module typed_operand_stack_with_registers
    import tosr_pkg::*;
#(
    parameter int STACK_DEPTH   = DEF_STACK_DEPTH,
    parameter int NUM_REGISTERS = DEF_NUM_REGISTERS
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // command[2:0], value_bits[66:3], register_index[71:67]
    input  logic [S_TDATA_W-1:0] s_tdata,
    // value_type[2:0]
    input  logic [S_TUSER_W-1:0] s_tuser,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // status[2:0], top_valid[3], top_bits[67:4], depth[74:68], zero fill above
    output logic [M_TDATA_W-1:0] m_tdata,
    // top_type[2:0]
    output logic [M_TUSER_W-1:0] m_tuser
);

    localparam int CW = $clog2(STACK_DEPTH + 1);
    localparam int RW = (NUM_REGISTERS > 1) ? $clog2(NUM_REGISTERS) : 1;

    logic [CMD_W-1:0]    command;
    logic [TAG_W-1:0]    value_type;
    logic [BITS_W-1:0]   value_bits;
    logic [RIDX_W-1:0]   register_index;

    assign command        = s_tdata[2:0];
    assign value_bits     = s_tdata[66:3];
    assign register_index = s_tdata[71:67];
    assign value_type     = s_tuser[2:0];

    logic accept;
    assign s_tready = !m_tvalid || m_tready;
    assign accept   = s_tvalid && s_tready;

    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;

    entry_t     cell_q    [STACK_DEPTH];
    entry_t     cell_d    [STACK_DEPTH];
    cell_ctrl_t cell_ctrl [STACK_DEPTH];

    entry_t new_entry;
    entry_t rd_entry;
    logic   rd_valid;

    logic    do_push;
    logic    do_pop;
    logic    do_swap;
    logic    do_clear;
    logic    reg_wr;
    status_t status;

    logic is_empty;
    logic is_full;
    logic idx_ok;

    assign is_empty = (count_reg == '0);
    assign is_full  = (count_reg == CW'(STACK_DEPTH));
    assign idx_ok   = ({1'b0, register_index} < (RIDX_W + 1)'(NUM_REGISTERS));

    always_comb
    begin
        do_push   = 1'b0;
        do_pop    = 1'b0;
        do_swap   = 1'b0;
        do_clear  = 1'b0;
        reg_wr    = 1'b0;
        status    = ST_OK;
        new_entry = '{tag: value_type, bits: value_bits};
        unique case (command)
            CMD_PUSH:
            begin
                if (is_full)
                begin
                    status = ST_FULL;
                end
                else
                begin
                    do_push = 1'b1;
                end
            end
            CMD_POP:
            begin
                if (is_empty)
                begin
                    status = ST_EMPTY;
                end
                else
                begin
                    do_pop = 1'b1;
                end
            end
            CMD_CLEAR:
            begin
                do_clear = 1'b1;
            end
            CMD_DUP:
            begin
                new_entry = cell_q[0];
                priority if (is_empty)
                begin
                    status = ST_EMPTY;
                end
                else if (is_full)
                begin
                    status = ST_FULL;
                end
                else
                begin
                    do_push = 1'b1;
                end
            end
            CMD_SWAP:
            begin
                if (count_reg < CW'(2))
                begin
                    status = ST_FEW;
                end
                else
                begin
                    do_swap = 1'b1;
                end
            end
            CMD_LOAD:
            begin
                new_entry = rd_entry;
                priority if (!idx_ok)
                begin
                    status = ST_RANGE;
                end
                else if (!rd_valid)
                begin
                    status = ST_REGEMPTY;
                end
                else if (is_full)
                begin
                    status = ST_FULL;
                end
                else
                begin
                    do_push = 1'b1;
                end
            end
            CMD_STORE:
            begin
                priority if (is_empty)
                begin
                    status = ST_EMPTY;
                end
                else if (!idx_ok)
                begin
                    status = ST_RANGE;
                end
                else
                begin
                    do_pop = 1'b1;
                    reg_wr = 1'b1;
                end
            end
            default:
            begin
                status = ST_OK;
            end
        endcase
    end

    always_comb
    begin
        priority if (!accept)
        begin
            count_next = count_reg;
        end
        else if (do_clear)
        begin
            count_next = '0;
        end
        else if (do_push)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (do_pop)
        begin
            count_next = count_reg - CW'(1);
        end
        else
        begin
            count_next = count_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    // Cell 0 is the top of the stack. A push moves every entry one cell down,
    // a pop moves every entry one cell up, and a swap exchanges cells 0 and 1.
    genvar i;
    generate
        for (i = 0; i < STACK_DEPTH; i++)
        begin : g_cell
            entry_t up_in;
            entry_t down_in;

            assign cell_ctrl[i].take_up   = accept && (do_push || (do_swap && (i == 1)));
            assign cell_ctrl[i].take_down = accept && (do_pop || (do_swap && (i == 0)));

            if (i == 0)
            begin : g_first
                assign up_in = new_entry;
            end
            else
            begin : g_mid
                assign up_in = cell_q[i-1];
            end

            if (i == STACK_DEPTH - 1)
            begin : g_last
                assign down_in = cell_q[i];
            end
            else
            begin : g_inner
                assign down_in = cell_q[i+1];
            end

            tosr_cell u_cell (
                .clk     (clk),
                .ctrl    (cell_ctrl[i]),
                .up_in   (up_in),
                .down_in (down_in),
                .q       (cell_q[i]),
                .d       (cell_d[i])
            );
        end
    endgenerate

    tosr_regfile #(
        .NUM_REGISTERS (NUM_REGISTERS),
        .RW            (RW)
    ) u_regfile (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (accept && reg_wr),
        .wr_idx   (register_index[RW-1:0]),
        .wr_entry (cell_q[0]),
        .rd_idx   (register_index[RW-1:0]),
        .rd_entry (rd_entry),
        .rd_valid (rd_valid)
    );

    // Result beat register.
    logic                out_valid_reg;
    logic                out_valid_next;
    logic [STATUS_W-1:0] status_reg;
    logic                top_valid_reg;
    entry_t              top_reg;
    logic [DEPTH_W-1:0]  depth_reg;
    logic                top_valid_next;
    logic [CW+DEPTH_W-1:0] count_ext;

    assign top_valid_next = (count_next != '0);
    assign count_ext      = {{DEPTH_W{1'b0}}, count_next};
    assign out_valid_next = accept || (m_tvalid && !m_tready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            status_reg    <= status;
            top_valid_reg <= top_valid_next;
            top_reg       <= top_valid_next ? cell_d[0] : '0;
            depth_reg     <= count_ext[DEPTH_W-1:0];
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {5'b0, depth_reg, top_reg.bits, top_valid_reg, status_reg};
    assign m_tuser  = top_reg.tag;

endmodule

### hdl/tosr_check.sv
module tosr_check
    import tosr_pkg::*;
(
    input logic                 clk,
    input logic                 rst_n,
    input logic                 s_tvalid,
    input logic                 s_tready,
    input logic [S_TDATA_W-1:0] s_tdata,
    input logic [S_TUSER_W-1:0] s_tuser,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [M_TDATA_W-1:0] m_tdata,
    input logic [M_TUSER_W-1:0] m_tuser
);

    // A stalled result beat keeps its contents.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result beat changed while stalled");

    // Every accepted command produces a result beat in the next cycle.
    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> m_tvalid)
        else $error("accepted command gave no result");

    // Input is held back only by a pending result that is not being taken.
    a_ready_blocked: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> m_tvalid && !m_tready)
        else $error("input stalled without output backpressure");

    // An empty stack reports zero depth and a zero top entry.
    a_empty_top: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tdata[3] |-> m_tdata[74:68] == 7'd0 && m_tdata[67:4] == 64'd0
            && m_tuser == 3'd0)
        else $error("empty stack shows a top entry or depth");

endmodule

bind typed_operand_stack_with_registers tosr_check u_tosr_check (.*);
